// ===== design/cdq_pkg.sv =====
package cdq_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam int VAL_W = 32;
  localparam int POS_W = 4;
  localparam int STAT_W = 2;
  localparam int ECNT_W = 5;
  localparam int OUT_FIELDS_W = VAL_W + 1 + POS_W + STAT_W + ECNT_W;
  localparam int OUT_DATA_W = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef enum logic [2:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_BACK  = 3'd1,
    OP_REM_FRONT = 3'd2,
    OP_REM_BACK  = 3'd3,
    OP_SEARCH    = 3'd4
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SEARCH,
    ST_DONE
  } state_t;

  localparam logic [IDX_W:0] DEPTH_X = (IDX_W + 1)'(DEPTH);

  function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] base,
                                                input logic [IDX_W-1:0] off);
    logic [IDX_W:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= DEPTH_X) begin
      sum = sum - DEPTH_X;
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

// ===== design/circular_deque_with_search.sv =====
// An accepted transaction goes from idle to the done state for inserts, refused
// requests, unknown operations and a search of an empty queue; a remove passes
// through the load state first, and a search through the search state, which
// compares one stored element per cycle. The next transaction is taken only when
// the result moves into the output register, and waits while that stalls.
// Reset (rst, synchronous) clears head, count and output valid, not the slots.
module circular_deque_with_search
  import cdq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [VAL_W-1:0]      s_tdata,   // value[31:0]
  input  logic [2:0]            s_tuser,   // operation[2:0]
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // removed_value[31:0], found[32], position[36:33], status[38:37],
  // element_count[43:39], zero fill[47:44]
  output logic [OUT_DATA_W-1:0] m_tdata
);

  logic [VAL_W-1:0] mem [DEPTH];
  logic [VAL_W-1:0] rd_data;

  state_t           state, state_next;
  logic [IDX_W-1:0] head, head_next;
  logic [CNT_W-1:0] count, count_next;
  logic [IDX_W-1:0] idx, idx_next;
  logic [VAL_W-1:0] val_r, val_next;
  logic [VAL_W-1:0] res_removed, res_removed_next;
  logic             res_found, res_found_next;
  logic [IDX_W-1:0] res_pos, res_pos_next;
  status_t          res_status, res_status_next;

  logic             rd_en, wr_en, out_load, accept, full, empty;
  logic [IDX_W-1:0] rd_addr, wr_addr;
  logic [CNT_W-1:0] idx_plus;

  assign accept   = s_tvalid && s_tready;
  assign s_tready = (state == ST_IDLE);
  assign full     = (count >= CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign idx_plus = CNT_W'(idx) + CNT_W'(1);

  always_comb begin
    state_next       = state;
    head_next        = head;
    count_next       = count;
    idx_next         = idx;
    val_next         = val_r;
    res_removed_next = res_removed;
    res_found_next   = res_found;
    res_pos_next     = res_pos;
    res_status_next  = res_status;
    rd_en            = 1'b0;
    rd_addr          = head;
    wr_en            = 1'b0;
    wr_addr          = head;
    out_load         = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          val_next         = s_tdata;
          res_removed_next = '0;
          res_found_next   = 1'b0;
          res_pos_next     = '0;
          res_status_next  = STAT_OK;
          state_next       = ST_DONE;
          unique case (s_tuser)
            OP_INS_FRONT: begin
              if (full) begin
                res_status_next = STAT_FULL;
              end else begin
                head_next  = (head == '0) ? IDX_W'(DEPTH - 1) : head - IDX_W'(1);
                wr_en      = 1'b1;
                wr_addr    = head_next;
                count_next = count + CNT_W'(1);
              end
            end
            OP_INS_BACK: begin
              if (full) begin
                res_status_next = STAT_FULL;
              end else begin
                wr_en      = 1'b1;
                wr_addr    = ring_add(head, count[IDX_W-1:0]);
                count_next = count + CNT_W'(1);
              end
            end
            OP_REM_FRONT: begin
              if (empty) begin
                res_status_next = STAT_EMPTY;
              end else begin
                rd_en      = 1'b1;
                rd_addr    = head;
                head_next  = ring_add(head, IDX_W'(1));
                count_next = count - CNT_W'(1);
                state_next = ST_LOAD;
              end
            end
            OP_REM_BACK: begin
              if (empty) begin
                res_status_next = STAT_EMPTY;
              end else begin
                count_next = count - CNT_W'(1);
                rd_en      = 1'b1;
                rd_addr    = ring_add(head, count_next[IDX_W-1:0]);
                state_next = ST_LOAD;
              end
            end
            OP_SEARCH: begin
              if (!empty) begin
                rd_en      = 1'b1;
                rd_addr    = head;
                idx_next   = '0;
                state_next = ST_SEARCH;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_LOAD: begin
        res_removed_next = rd_data;
        state_next       = ST_DONE;
      end
      ST_SEARCH: begin
        if (rd_data == val_r) begin
          res_found_next = 1'b1;
          res_pos_next   = idx;
          state_next     = ST_DONE;
        end else if (idx_plus == count) begin
          state_next = ST_DONE;
        end else begin
          idx_next = idx_plus[IDX_W-1:0];
          rd_en    = 1'b1;
          rd_addr  = ring_add(head, idx_plus[IDX_W-1:0]);
        end
      end
      ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= s_tdata;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      head     <= '0;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      count <= count_next;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx         <= idx_next;
    val_r       <= val_next;
    res_removed <= res_removed_next;
    res_found   <= res_found_next;
    res_pos     <= res_pos_next;
    res_status  <= res_status_next;
    if (out_load) begin
      m_tdata <= OUT_DATA_W'({ECNT_W'(count), res_status, POS_W'(res_pos),
                              res_found, res_removed});
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("element count exceeds depth");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (accept && (s_tuser == OP_INS_FRONT || s_tuser == OP_INS_BACK) && !full)
      |=> (count == $past(count) + CNT_W'(1)))
    else $error("insert did not grow the count");

  a_search_stable: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEARCH) |=> ($stable(count) && $stable(head)))
    else $error("search changed the queue");

  a_busy_no_ready: assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_tready)
    else $error("ready while a transaction is in progress");
`endif

endmodule
